@@ rtl/core/bkmi_pkg.sv @@
package bkmi_pkg;

  // Grid geometry
  localparam int MAX_X_POINTS = 64;
  localparam int MAX_Z_POINTS = 64;
  localparam int XA_W = 6;
  localparam int ZA_W = 6;
  localparam int CNT_W = 7;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_WR_X   = 2'd1,
    OP_WR_Z   = 2'd2,
    OP_WR_MAP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MAP_KX_FIRST  = 3'd0,
    MAP_KZ_FIRST  = 3'd1,
    MAP_KX_SECOND = 3'd2,
    MAP_KZ_SECOND = 3'd3,
    MAP_LONG      = 3'd4
  } map_sel_t;

  typedef enum logic [2:0] {
    CFG_MAP_ORDER   = 3'd0,
    CFG_LONG_ENABLE = 3'd1,
    CFG_X_COUNT     = 3'd2,
    CFG_Z_COUNT     = 3'd3,
    CFG_X_INV_STEP  = 3'd4,
    CFG_Z_INV_STEP  = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] ORDER_FIRST  = 2'd1;
  localparam logic [1:0] ORDER_SECOND = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic wr;          // load transfer accepted
    logic ld;          // query transfer accepted
    logic edge0;
    logic edge1;
    logic edge2;
    logic scan_start;
    logic scan;
    logic ax_rd;
    logic diff_ld;
    logic wgt_ld;
    logic map_rd;
    logic mul;
    logic acc;
    logic res_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic oor;
    logic order_ok;
    logic scan_done;
    logic corner_last;
    logic out_busy;
  } sts_t;

  // Grid points in use, kept within [2, lim]
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                   input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    r = c;
    if (c < CNT_W'(2)) r = CNT_W'(2);
    else if (c > lim) r = lim;
    return r;
  endfunction

endpackage

@@ rtl/core/bkmi_req_if.sv @@
interface bkmi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  map_select;
  logic [5:0]  x_index;
  logic [5:0]  z_index;
  logic signed [31:0] write_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_z;

  modport source (output valid, opcode, map_select, x_index, z_index, write_value,
                  pos_x, pos_z, input ready);
  modport sink (input valid, opcode, map_select, x_index, z_index, write_value,
                pos_x, pos_z, output ready);
endinterface

interface bkmi_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] kick_x;
  logic signed [31:0] kick_z;
  logic signed [31:0] long_term;
  logic        out_of_range;

  modport source (output valid, kick_x, kick_z, long_term, out_of_range, input ready);
  modport sink (input valid, kick_x, kick_z, long_term, out_of_range, output ready);
endinterface

@@ rtl/core/bkmi_ctrl.sv @@
module bkmi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_opcode,
  output logic          in_ready,
  input  bkmi_pkg::sts_t sts,
  output bkmi_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_EDGE0 = 13'b0000000000010,
    S_EDGE1 = 13'b0000000000100,
    S_EDGE2 = 13'b0000000001000,
    S_CHECK = 13'b0000000010000,
    S_SCAN  = 13'b0000000100000,
    S_AXRD  = 13'b0000001000000,
    S_AXWT  = 13'b0000010000000,
    S_WGT   = 13'b0000100000000,
    S_MRD   = 13'b0001000000000,
    S_MUL   = 13'b0010000000000,
    S_ACC   = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   in_acc;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == bkmi_pkg::OP_QUERY) begin
            cmd.ld = 1'b1;
            state_next = S_EDGE0;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_EDGE0: begin
        cmd.edge0 = 1'b1;
        state_next = S_EDGE1;
      end
      S_EDGE1: begin
        cmd.edge1 = 1'b1;
        state_next = S_EDGE2;
      end
      S_EDGE2: begin
        cmd.edge2 = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.oor || !sts.order_ok) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_AXRD;
      end
      S_AXRD: begin
        cmd.ax_rd = 1'b1;
        state_next = S_AXWT;
      end
      S_AXWT: begin
        cmd.diff_ld = 1'b1;
        state_next = S_WGT;
      end
      S_WGT: begin
        cmd.wgt_ld = 1'b1;
        state_next = S_MRD;
      end
      S_MRD: begin
        cmd.map_rd = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_next = sts.corner_last ? S_FIN : S_MRD;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

@@ rtl/core/bkmi_dp.sv @@
module bkmi_dp (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // request payload
  input  logic [1:0]          in_opcode,
  input  logic [2:0]          in_map_select,
  input  logic [5:0]          in_x_index,
  input  logic [5:0]          in_z_index,
  input  logic signed [31:0]  in_write_value,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_z,
  // result
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_kick_x,
  output logic signed [31:0]  out_kick_z,
  output logic signed [31:0]  out_long_term,
  output logic                out_of_range,
  input  bkmi_pkg::cmd_t      cmd,
  output bkmi_pkg::sts_t      sts
);

  localparam int XA = bkmi_pkg::XA_W;
  localparam int ZA = bkmi_pkg::ZA_W;
  localparam int CW = bkmi_pkg::CNT_W;
  localparam int MD = bkmi_pkg::MAX_X_POINTS * bkmi_pkg::MAX_Z_POINTS;

  // Configuration registers
  logic [1:0]  map_order;
  logic        long_enable;
  logic [CW-1:0] x_count, z_count;
  logic [31:0] x_inv_step, z_inv_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_order   <= 2'd2;
      long_enable <= 1'b0;
      x_count     <= CW'(64);
      z_count     <= CW'(64);
      x_inv_step  <= 32'd65536;
      z_inv_step  <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        bkmi_pkg::CFG_MAP_ORDER:   map_order   <= cfg_data[1:0];
        bkmi_pkg::CFG_LONG_ENABLE: long_enable <= cfg_data[0];
        bkmi_pkg::CFG_X_COUNT:     x_count     <= cfg_data[CW-1:0];
        bkmi_pkg::CFG_Z_COUNT:     z_count     <= cfg_data[CW-1:0];
        bkmi_pkg::CFG_X_INV_STEP:  x_inv_step  <= cfg_data;
        bkmi_pkg::CFG_Z_INV_STEP:  z_inv_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Axis and map memories
  logic signed [31:0] x_mem [bkmi_pkg::MAX_X_POINTS];
  logic signed [31:0] z_mem [bkmi_pkg::MAX_Z_POINTS];
  logic signed [31:0] kxf_mem [MD];
  logic signed [31:0] kzf_mem [MD];
  logic signed [31:0] kxs_mem [MD];
  logic signed [31:0] kzs_mem [MD];
  logic signed [31:0] lng_mem [MD];

  logic [XA-1:0] x_raddr;
  logic [ZA-1:0] z_raddr;
  logic [XA+ZA-1:0] m_raddr, m_waddr;
  logic signed [31:0] x_q, z_q, kxf_q, kzf_q, kxs_q, kzs_q, lng_q;
  logic wr_x, wr_z, wr_map;

  assign wr_x   = cmd.wr && (in_opcode == bkmi_pkg::OP_WR_X);
  assign wr_z   = cmd.wr && (in_opcode == bkmi_pkg::OP_WR_Z);
  assign wr_map = cmd.wr && (in_opcode == bkmi_pkg::OP_WR_MAP);
  assign m_waddr = {in_z_index, in_x_index};

  always_ff @(posedge clk) begin
    if (wr_x) x_mem[in_x_index] <= in_write_value;
    if (wr_z) z_mem[in_z_index] <= in_write_value;
    x_q <= x_mem[x_raddr];
    z_q <= z_mem[z_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_map && in_map_select == bkmi_pkg::MAP_KX_FIRST)  kxf_mem[m_waddr] <= in_write_value;
    if (wr_map && in_map_select == bkmi_pkg::MAP_KZ_FIRST)  kzf_mem[m_waddr] <= in_write_value;
    if (wr_map && in_map_select == bkmi_pkg::MAP_KX_SECOND) kxs_mem[m_waddr] <= in_write_value;
    if (wr_map && in_map_select == bkmi_pkg::MAP_KZ_SECOND) kzs_mem[m_waddr] <= in_write_value;
    if (wr_map && in_map_select == bkmi_pkg::MAP_LONG)      lng_mem[m_waddr] <= in_write_value;
    kxf_q <= kxf_mem[m_raddr];
    kzf_q <= kzf_mem[m_raddr];
    kxs_q <= kxs_mem[m_raddr];
    kzs_q <= kzs_mem[m_raddr];
    lng_q <= lng_mem[m_raddr];
  end

  // Query registers
  logic signed [31:0] px, pz, x_lo;
  logic signed [31:0] z_hi;
  logic [CW-1:0] nx, nz;
  logic oor;

  // Scan state
  logic [CW-1:0] sx, sz;
  logic [XA-1:0] sidx_x;
  logic [ZA-1:0] sidx_z;
  logic sv, x_done, z_done;
  logic [XA-1:0] ix;
  logic [ZA-1:0] iz;
  logic [XA-1:0] nx_m1, nx_m2;
  logic [ZA-1:0] nz_m1, nz_m2;

  assign nx_m1 = XA'(nx - CW'(1));
  assign nx_m2 = XA'(nx - CW'(2));
  assign nz_m1 = ZA'(nz - CW'(1));
  assign nz_m2 = ZA'(nz - CW'(2));

  // Corner sequencing
  logic [1:0] corner;
  logic [XA-1:0] cx;
  logic [ZA-1:0] cz;
  assign cx = ix + XA'(corner[0]);
  assign cz = iz + ZA'(corner[1]);

  // Axis read address select
  always_comb begin
    x_raddr = sx[XA-1:0];
    z_raddr = sz[ZA-1:0];
    if (cmd.edge0) begin
      x_raddr = '0;
      z_raddr = '0;
    end else if (cmd.edge1) begin
      x_raddr = nx_m1;
      z_raddr = nz_m1;
    end else if (cmd.ax_rd) begin
      x_raddr = ix;
      z_raddr = iz;
    end
  end
  assign m_raddr = {cz, cx};

  // Edge test and cell scan
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      px <= in_pos_x;
      pz <= in_pos_z;
      nx <= bkmi_pkg::clamp_count(x_count, CW'(bkmi_pkg::MAX_X_POINTS));
      nz <= bkmi_pkg::clamp_count(z_count, CW'(bkmi_pkg::MAX_Z_POINTS));
    end
    if (cmd.edge1) begin
      x_lo <= x_q;
      z_hi <= z_q;
    end
    if (cmd.edge2) begin
      oor <= (px < x_lo) || (px > x_q) || (pz > z_hi) || (pz < z_q);
    end
    if (cmd.scan_start) begin
      sx <= '0;
      sz <= '0;
      sv <= 1'b0;
      x_done <= 1'b0;
      z_done <= 1'b0;
    end else if (cmd.scan) begin
      sx <= sx + CW'(1);
      sz <= sz + CW'(1);
      sidx_x <= sx[XA-1:0];
      sidx_z <= sz[ZA-1:0];
      sv <= 1'b1;
      if (sv && !x_done) begin
        if (!(px >= x_q)) begin
          ix <= sidx_x - XA'(1);
          x_done <= 1'b1;
        end else if (sidx_x == nx_m1) begin
          ix <= nx_m2;
          x_done <= 1'b1;
        end
      end
      if (sv && !z_done) begin
        if (!(pz <= z_q)) begin
          iz <= sidx_z - ZA'(1);
          z_done <= 1'b1;
        end else if (sidx_z == nz_m1) begin
          iz <= nz_m2;
          z_done <= 1'b1;
        end
      end
    end
  end

  // Weights
  logic signed [32:0] dx, dz;
  logic signed [65:0] wpx, wpz;
  logic [39:0] wqx, wqz;
  logic [16:0] u, t, wa, wb;
  logic [33:0] wprod;
  logic [32:0] w;

  assign wpx = dx * $signed({1'b0, x_inv_step});
  assign wpz = dz * $signed({1'b0, z_inv_step});
  assign wqx = wpx[63:24];
  assign wqz = wpz[63:24];
  assign wa = corner[0] ? u : (bkmi_pkg::ONE_Q16 - u);
  assign wb = corner[1] ? t : (bkmi_pkg::ONE_Q16 - t);
  assign wprod = wa * wb;

  always_ff @(posedge clk) begin
    if (cmd.diff_ld) begin
      dx <= {px[31], px} - {x_q[31], x_q};
      dz <= {z_q[31], z_q} - {pz[31], pz};
    end
    if (cmd.wgt_ld) begin
      u <= (wqx > 40'd65536) ? bkmi_pkg::ONE_Q16 : wqx[16:0];
      t <= (wqz > 40'd65536) ? bkmi_pkg::ONE_Q16 : wqz[16:0];
    end
    if (cmd.map_rd) w <= wprod[32:0];
  end

  // Multiply and accumulate, one corner at a time
  logic signed [31:0] vx, vz;
  logic signed [65:0] px_full, pz_full, pl_full;
  logic [63:0] prod_x, prod_z, prod_l, acc_x, acc_z, acc_l;
  logic [63:0] rnd_x, rnd_z, rnd_l;
  logic order2;

  assign order2 = (map_order == bkmi_pkg::ORDER_SECOND);
  assign vx = order2 ? kxs_q : kxf_q;
  assign vz = order2 ? kzs_q : kzf_q;
  assign px_full = vx * $signed({1'b0, w});
  assign pz_full = vz * $signed({1'b0, w});
  assign pl_full = lng_q * $signed({1'b0, w});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x <= px_full[63:0];
      prod_z <= pz_full[63:0];
      prod_l <= pl_full[63:0];
    end
    if (cmd.ax_rd) begin
      acc_x <= '0;
      acc_z <= '0;
      acc_l <= '0;
      corner <= '0;
    end else if (cmd.acc) begin
      acc_x <= acc_x + prod_x;
      acc_z <= acc_z + prod_z;
      acc_l <= acc_l + prod_l;
      corner <= corner + 2'd1;
    end
  end

  assign rnd_x = acc_x + 64'h8000_0000;
  assign rnd_z = acc_z + 64'h8000_0000;
  assign rnd_l = acc_l + 64'h8000_0000;

  // Result register
  logic use_maps;
  assign use_maps = !oor && sts.order_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.res_load) begin
      out_of_range  <= oor;
      out_kick_x    <= use_maps ? rnd_x[63:32] : '0;
      out_kick_z    <= use_maps ? rnd_z[63:32] : '0;
      out_long_term <= (use_maps && order2 && long_enable) ? rnd_l[63:32] : '0;
    end
  end

  assign sts.oor         = oor;
  assign sts.order_ok    = (map_order == bkmi_pkg::ORDER_FIRST) || order2;
  assign sts.scan_done   = x_done && z_done;
  assign sts.corner_last = (corner == 2'd3);
  assign sts.out_busy    = out_valid && !out_ready;

endmodule

@@ rtl/core/bilinear_kick_map_interpolation_top.sv @@
// Bilinear kick-map interpolator.
// Load transfers are taken in idle and return nothing; the next transfer can follow at once.
// Queries run the edge test, then an axis scan of one entry per cycle, then a four-corner
// multiply-accumulate; the result is loaded once the previous result has been taken.
// Out-of-range or unknown order queries skip the scan and the multiply-accumulate.
// One query at a time; the next transfer is taken in the cycle after the result is loaded.
// Synchronous active-high reset restores the configuration; memories are not cleared.
module bilinear_kick_map_interpolation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  bkmi_req_if.sink    req,
  bkmi_rsp_if.source  rsp
);

  bkmi_pkg::cmd_t cmd;
  bkmi_pkg::sts_t sts;

  bkmi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_opcode (req.opcode),
    .in_ready  (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bkmi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_opcode      (req.opcode),
    .in_map_select  (req.map_select),
    .in_x_index     (req.x_index),
    .in_z_index     (req.z_index),
    .in_write_value (req.write_value),
    .in_pos_x       (req.pos_x),
    .in_pos_z       (req.pos_z),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_kick_x     (rsp.kick_x),
    .out_kick_z     (rsp.kick_z),
    .out_long_term  (rsp.long_term),
    .out_of_range   (rsp.out_of_range),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

@@ rtl/core/bkmi_checker.sv @@
module bkmi_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_opcode,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_kick_x,
  input logic [31:0] rsp_kick_z,
  input logic [31:0] rsp_long_term,
  input logic        rsp_out_of_range
);

  // No result straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kick_x) && $stable(rsp_kick_z)
      && $stable(rsp_long_term) && $stable(rsp_out_of_range))
    else $error("stalled result changed");

  // Out of range gives zero kicks
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_out_of_range |-> rsp_kick_x == 32'd0 && rsp_kick_z == 32'd0
      && rsp_long_term == 32'd0)
    else $error("nonzero kick with out of range");

  // A query keeps the block busy next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_opcode == bkmi_pkg::OP_QUERY |=> !req_ready)
    else $error("ready straight after a query");

endmodule

bind bilinear_kick_map_interpolation_top bkmi_checker u_bkmi_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_opcode       (req.opcode),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_kick_x       (rsp.kick_x),
  .rsp_kick_z       (rsp.kick_z),
  .rsp_long_term    (rsp.long_term),
  .rsp_out_of_range (rsp.out_of_range)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 400000;        // cycles before the run is abandoned
  localparam int SETTLE = 120;          // cycles of quiet after the last result
  localparam int HOLD_OFF = 300;        // long receiver stall
  localparam logic [2:0] CFG_SPARE = 3'd6;  // unused register index

  typedef struct {
    bkmi_pkg::op_t     op;
    logic [2:0]        sel;
    logic [5:0]        xi;
    logic [5:0]        zi;
    logic signed [31:0] wv;
    logic signed [31:0] px;
    logic signed [31:0] pz;
  } kick_req_t;

  typedef struct {
    logic signed [31:0] kx;
    logic signed [31:0] kz;
    logic signed [31:0] lt;
    logic               oor;
  } kick_res_t;

  // Predictor of the interpolator plus the queue of kicks still to come
  class kick_scoreboard;
    logic [1:0]  order = bkmi_pkg::ORDER_SECOND;
    bit          long_en = 0;
    logic [6:0]  xn = 7'd64;
    logic [6:0]  zn = 7'd64;
    logic [31:0] xinv = 32'd65536;
    logic [31:0] zinv = 32'd65536;
    bit signed [31:0] xax[bkmi_pkg::MAX_X_POINTS];
    bit signed [31:0] zax[bkmi_pkg::MAX_Z_POINTS];
    bit signed [31:0] maps[5][bkmi_pkg::MAX_X_POINTS*bkmi_pkg::MAX_Z_POINTS];
    kick_res_t   pending[$];
    int          errors = 0;
    int          n_checked = 0;
    int          n_oor = 0;

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        bkmi_pkg::CFG_MAP_ORDER:   order = v[1:0];
        bkmi_pkg::CFG_LONG_ENABLE: long_en = v[0];
        bkmi_pkg::CFG_X_COUNT:     xn = v[6:0];
        bkmi_pkg::CFG_Z_COUNT:     zn = v[6:0];
        bkmi_pkg::CFG_X_INV_STEP:  xinv = v;
        bkmi_pkg::CFG_Z_INV_STEP:  zinv = v;
        default: ;
      endcase
    endfunction

    function int span(logic [6:0] c, int lim);
      if (c < 2) return 2;
      if (c > lim) return lim;
      return c;
    endfunction

    // Q1.16 weight, saturating at 1.0
    function logic [16:0] weight(longint d, logic [31:0] inv);
      logic [63:0] w;
      w = (64'(d) * {32'd0, inv}) >> 24;
      return (w > 64'd65536) ? bkmi_pkg::ONE_Q16 : w[16:0];
    endfunction

    // four-corner blend, rounded half up, modulo 2^64 like the hardware sum
    function logic signed [31:0] blend(int m, int base, logic [16:0] u, logic [16:0] t);
      logic [63:0] cu, ct, s;
      cu = 64'(bkmi_pkg::ONE_Q16 - u);
      ct = 64'(bkmi_pkg::ONE_Q16 - t);
      s = 64'(longint'(maps[m][base])) * (cu * ct)
        + 64'(longint'(maps[m][base + 1])) * (64'(u) * ct)
        + 64'(longint'(maps[m][base + bkmi_pkg::MAX_X_POINTS])) * (cu * 64'(t))
        + 64'(longint'(maps[m][base + bkmi_pkg::MAX_X_POINTS + 1])) * (64'(u) * 64'(t));
      s = s + 64'h8000_0000_8000_0000;
      return 32'((s >> 32) - 64'h8000_0000);
    endfunction

    function kick_res_t predict(logic signed [31:0] px, logic signed [31:0] pz);
      kick_res_t r;
      int nx, nz, ix, iz, base;
      logic [16:0] u, t;
      r.kx = 0; r.kz = 0; r.lt = 0; r.oor = 0;
      nx = span(xn, bkmi_pkg::MAX_X_POINTS);
      nz = span(zn, bkmi_pkg::MAX_Z_POINTS);
      if (px < xax[0] || px > xax[nx-1] || pz > zax[0] || pz < zax[nz-1]) begin
        r.oor = 1;
        return r;
      end
      // cell search, clamped at the upper edge
      ix = 0;
      while (ix < nx && px >= xax[ix]) ix++;
      ix--;
      if (ix > nx - 2) ix = nx - 2;
      iz = 0;
      while (iz < nz && pz <= zax[iz]) iz++;
      iz--;
      if (iz > nz - 2) iz = nz - 2;
      u = weight(longint'(px) - longint'(xax[ix]), xinv);
      t = weight(longint'(zax[iz]) - longint'(pz), zinv);
      base = iz * bkmi_pkg::MAX_X_POINTS + ix;
      if (order == bkmi_pkg::ORDER_FIRST) begin
        r.kx = blend(bkmi_pkg::MAP_KX_FIRST, base, u, t);
        r.kz = blend(bkmi_pkg::MAP_KZ_FIRST, base, u, t);
      end else if (order == bkmi_pkg::ORDER_SECOND) begin
        r.kx = blend(bkmi_pkg::MAP_KX_SECOND, base, u, t);
        r.kz = blend(bkmi_pkg::MAP_KZ_SECOND, base, u, t);
        if (long_en) r.lt = blend(bkmi_pkg::MAP_LONG, base, u, t);
      end
      return r;
    endfunction

    // accepted request transfer
    function void note(kick_req_t it);
      case (it.op)
        bkmi_pkg::OP_WR_X:   xax[it.xi] = it.wv;
        bkmi_pkg::OP_WR_Z:   zax[it.zi] = it.wv;
        bkmi_pkg::OP_WR_MAP: if (it.sel <= bkmi_pkg::MAP_LONG) maps[it.sel][{it.zi, it.xi}] = it.wv;
        default:   pending.push_back(predict(it.px, it.pz));
      endcase
    endfunction

    // accepted result transfer
    function void check(kick_res_t got);
      kick_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h %h %h %b", $time,
                 got.kx, got.kz, got.lt, got.oor);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      n_checked++;
      if (exp_r.oor) n_oor++;
      if (got.kx !== exp_r.kx) begin
        $display("%0t: kick_x expected %h, actual %h", $time, exp_r.kx, got.kx);
        errors++;
      end
      if (got.kz !== exp_r.kz) begin
        $display("%0t: kick_z expected %h, actual %h", $time, exp_r.kz, got.kz);
        errors++;
      end
      if (got.lt !== exp_r.lt) begin
        $display("%0t: long_term expected %h, actual %h", $time, exp_r.lt, got.lt);
        errors++;
      end
      if (got.oor !== exp_r.oor) begin
        $display("%0t: out_of_range expected %b, actual %b", $time, exp_r.oor, got.oor);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  bkmi_req_if req();
  bkmi_rsp_if rsp();

  bilinear_kick_map_interpolation_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  kick_scoreboard sb = new();

  bit idle_on = 1;
  bit hold_req = 0;
  int cycles = 0;
  int n_sent = 0;

  // driver's own view of the grid, used to keep reads on written cells
  logic signed [31:0] xa[bkmi_pkg::MAX_X_POINTS];
  logic signed [31:0] za[bkmi_pkg::MAX_Z_POINTS];
  int sx, sz;
  int cur_nx = 64;
  int cur_nz = 64;
  bit written[5][bkmi_pkg::MAX_X_POINTS*bkmi_pkg::MAX_Z_POINTS];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // request transfers feed the predictor
  always @(posedge clk) begin : watch_req
    kick_req_t it;
    if (!rst && req.valid && req.ready) begin
      it.op = bkmi_pkg::op_t'(req.opcode);
      it.sel = req.map_select;
      it.xi = req.x_index;
      it.zi = req.z_index;
      it.wv = req.write_value;
      it.px = req.pos_x;
      it.pz = req.pos_z;
      sb.note(it);
    end
  end

  // result transfers are checked
  always @(posedge clk) begin : watch_rsp
    kick_res_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.kx = rsp.kick_x;
      got.kz = rsp.kick_z;
      got.lt = rsp.long_term;
      got.oor = rsp.out_of_range;
      sb.check(got);
    end
  end

  // receiver: bursts of stall, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send(kick_req_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= it.op;
    req.map_select <= it.sel;
    req.x_index <= it.xi;
    req.z_index <= it.zi;
    req.write_value <= it.wv;
    req.pos_x <= it.px;
    req.pos_z <= it.pz;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic load(bkmi_pkg::op_t op, logic [2:0] sel, int xi, int zi,
                      logic signed [31:0] v);
    kick_req_t it;
    it.op = op; it.sel = sel; it.xi = 6'(xi); it.zi = 6'(zi);
    it.wv = v; it.px = $urandom; it.pz = $urandom;
    if (op == bkmi_pkg::OP_WR_MAP && sel <= bkmi_pkg::MAP_LONG)
      written[sel][zi * bkmi_pkg::MAX_X_POINTS + xi] = 1;
    send(it);
  endtask

  task automatic query(logic signed [31:0] px, logic signed [31:0] pz);
    kick_req_t it;
    it.op = bkmi_pkg::OP_QUERY; it.sel = 3'($urandom); it.xi = 6'($urandom);
    it.zi = 6'($urandom); it.wv = $urandom; it.px = px; it.pz = pz;
    send(it);
  endtask

  function automatic logic signed [31:0] map_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 0;
      default: return $urandom;
    endcase
  endfunction

  // maps that a query reads under the present settings
  function automatic bit map_in_use(int m);
    if (sb.order == bkmi_pkg::ORDER_FIRST)
      return m == bkmi_pkg::MAP_KX_FIRST || m == bkmi_pkg::MAP_KZ_FIRST;
    if (sb.order == bkmi_pkg::ORDER_SECOND)
      return m == bkmi_pkg::MAP_KX_SECOND || m == bkmi_pkg::MAP_KZ_SECOND
          || (m == bkmi_pkg::MAP_LONG && sb.long_en);
    return 0;
  endfunction

  // make sure all four corners of a cell hold data in every map that is read
  task automatic fill_cell(int ix, int iz);
    for (int m = 0; m < 5; m++)
      if (map_in_use(m))
        for (int dz = 0; dz < 2; dz++)
          for (int dx = 0; dx < 2; dx++)
            if (!written[m][(iz + dz) * bkmi_pkg::MAX_X_POINTS + ix + dx])
              load(bkmi_pkg::OP_WR_MAP, 3'(m), ix + dx, iz + dz, map_value());
  endtask

  task automatic cell_query(int ix, int iz);
    logic signed [31:0] px, pz;
    fill_cell(ix, iz);
    px = xa[ix] + $urandom_range(0, (ix == cur_nx - 2) ? sx : sx - 1);
    pz = za[iz] - $urandom_range(0, (iz == cur_nz - 2) ? sz : sz - 1);
    query(px, pz);
  endtask

  // mostly cells near the origin, now and then the far corner cell
  task automatic any_cell_query();
    int ix, iz;
    if ($urandom_range(0, 5) == 0) begin
      ix = cur_nx - 2;
      iz = cur_nz - 2;
    end else begin
      ix = $urandom_range(0, (cur_nx > 4) ? 2 : cur_nx - 2);
      iz = $urandom_range(0, (cur_nz > 4) ? 2 : cur_nz - 2);
    end
    cell_query(ix, iz);
  endtask

  // fully random position pushed out of the map on one axis
  task automatic outside_query();
    logic signed [31:0] px, pz;
    px = $urandom;
    pz = $urandom;
    if ($urandom_range(0, 1)) begin
      while (px >= xa[0] && px <= xa[cur_nx-1]) px = $urandom;
    end else begin
      while (pz <= za[0] && pz >= za[cur_nz-1]) pz = $urandom;
    end
    query(px, pz);
  endtask

  task automatic noise();
    int i;
    i = $urandom_range(0, bkmi_pkg::MAX_X_POINTS - 1);
    case ($urandom_range(0, 2))
      0: load(bkmi_pkg::OP_WR_MAP, 3'($urandom_range(0, 7)), $urandom_range(0, 63),
              $urandom_range(0, 63), map_value());
      1: load(bkmi_pkg::OP_WR_X, 3'($urandom), i, $urandom_range(0, 63), xa[i]);
      default: load(bkmi_pkg::OP_WR_Z, 3'($urandom), $urandom_range(0, 63), i, za[i]);
    endcase
  endtask

  // wait for every result, then let the block settle
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(logic [1:0] order, bit le, logic [6:0] xn, logic [6:0] zn,
                       logic [31:0] xinv, logic [31:0] zinv);
    drain();
    cfg_write(bkmi_pkg::CFG_MAP_ORDER, 32'(order));
    cfg_write(bkmi_pkg::CFG_LONG_ENABLE, 32'(le));
    cfg_write(bkmi_pkg::CFG_X_COUNT, 32'(xn));
    cfg_write(bkmi_pkg::CFG_Z_COUNT, 32'(zn));
    cfg_write(bkmi_pkg::CFG_X_INV_STEP, xinv);
    cfg_write(bkmi_pkg::CFG_Z_INV_STEP, zinv);
    cur_nx = sb.span(xn, bkmi_pkg::MAX_X_POINTS);
    cur_nz = sb.span(zn, bkmi_pkg::MAX_Z_POINTS);
  endtask

  function automatic logic [31:0] inv_of(int step);
    return 32'((64'd1 << 40) / step);
  endfunction

  function automatic logic [6:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return 7'd127;
      default: return 7'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [31:0] pick_inv(int step);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return inv_of(step);
    endcase
  endfunction

  task automatic run_phase(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 6) any_cell_query();
      else if (r < 8) outside_query();
      else noise();
    end
  endtask

  initial begin
    logic signed [31:0] x0, z0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.opcode <= bkmi_pkg::OP_QUERY;
    req.map_select <= '0;
    req.x_index <= '0;
    req.z_index <= '0;
    req.write_value <= '0;
    req.pos_x <= '0;
    req.pos_z <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // regular grid: x rising, z falling
    sx = $urandom_range(1 << 16, 1 << 23);
    sz = $urandom_range(1 << 16, 1 << 23);
    x0 = -$signed(32'($urandom_range(0, 1 << 29)));
    z0 = $urandom_range(0, 1 << 29);
    for (int i = 0; i < bkmi_pkg::MAX_X_POINTS; i++) begin
      xa[i] = x0 + i * sx;
      load(bkmi_pkg::OP_WR_X, bkmi_pkg::MAP_KX_FIRST, i, 0, xa[i]);
    end
    for (int i = 0; i < bkmi_pkg::MAX_Z_POINTS; i++) begin
      za[i] = z0 - i * sz;
      load(bkmi_pkg::OP_WR_Z, bkmi_pkg::MAP_KX_FIRST, 0, i, za[i]);
    end

    // directed: reset settings, grid corners, exact edges, each side outside
    load(bkmi_pkg::OP_WR_MAP, bkmi_pkg::MAP_LONG, 1, 1, 32'sh8000_0000);
    load(bkmi_pkg::OP_WR_MAP, bkmi_pkg::MAP_KX_SECOND, 1, 1, 32'sh7FFF_FFFF);
    load(bkmi_pkg::OP_WR_MAP, 3'd7, 5, 5, 32'sh1234_5678);
    cell_query(0, 0);
    cell_query(1, 1);
    cell_query(62, 62);
    query(xa[0], za[0]);
    query(xa[63], za[63]);
    query(xa[0] - 1, za[10]);
    query(xa[63] + 1, za[10]);
    query(xa[10], za[0] + 1);
    query(xa[10], za[63] - 1);
    query(32'sh8000_0000, 32'sh7FFF_FFFF);
    setup(bkmi_pkg::ORDER_SECOND, 1, 7'd64, 7'd64, inv_of(sx), inv_of(sz));
    cell_query(62, 62);
    cell_query(0, 62);
    fill_cell(62, 0);
    query(xa[63], za[0]);
    drain();
    cfg_write(CFG_SPARE, $urandom);

    // random phases across the register space
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: setup(bkmi_pkg::ORDER_FIRST, 0, 7'd2, 7'd2, inv_of(sx), inv_of(sz));
        1: setup(bkmi_pkg::ORDER_SECOND, 1, 7'd64, 7'd64, 32'd0, 32'hFFFF_FFFF);
        2: setup(2'd0, 1, 7'd5, 7'd127, inv_of(sx), inv_of(sz));
        3: setup(2'd3, 0, 7'd1, 7'd0, inv_of(sx), inv_of(sz));
        4: setup(bkmi_pkg::ORDER_SECOND, 1, 7'd127, 7'd3, 32'hFFFF_FFFF, 32'd0);
        default: setup($urandom_range(0, 5) < 2 ? bkmi_pkg::ORDER_FIRST
                                                : bkmi_pkg::ORDER_SECOND,
                       1'($urandom_range(0, 1)), pick_count(), pick_count(),
                       pick_inv(sx), pick_inv(sz));
      endcase
      idle_on = (p < 8);
      if (p == 5) begin
        // receiver stalls while queries keep coming
        hold_req = 1;
        repeat (6) any_cell_query();
      end
      run_phase(16);
    end

    drain();
    $display("Run covered %0d transfers in, %0d kicks checked (%0d outside the map),",
             n_sent, sb.n_checked, sb.n_oor);
    $display("over both map orders, unused orders, clamped counts and extreme steps.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
